@@ hw/rtl/hsfd_pkg.sv @@
package hsfd_pkg;

    localparam int unsigned WIDTH_W = 16;
    localparam int unsigned COUNT_W = 6;

    localparam logic [WIDTH_W-1:0] LEADER_THR_RST = 16'h0288;
    localparam logic [WIDTH_W-1:0] ONE_THR_RST    = 16'h01A7;

    // Bit counts after which a byte boundary or the frame end is reached
    localparam logic [COUNT_W-1:0] CNT_HUM_HI   = 6'd8;
    localparam logic [COUNT_W-1:0] CNT_HUM_END  = 6'd16;
    localparam logic [COUNT_W-1:0] CNT_TEMP_HI  = 6'd24;
    localparam logic [COUNT_W-1:0] CNT_TEMP_END = 6'd32;
    localparam logic [COUNT_W-1:0] CNT_FRAME    = 6'd40;

    typedef enum logic [1:0] {
        CFG_LEADER_THR = 2'd0,
        CFG_ONE_THR    = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        OP_START = 1'b0,
        OP_PULSE = 1'b1
    } t_op;

    typedef struct packed {
        logic [WIDTH_W-1:0] leader;
        logic [WIDTH_W-1:0] one;
    } t_thresholds;

    typedef struct packed {
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic        checksum_ok;
        logic        protocol_error;
    } t_result;

endpackage

@@ hw/rtl/humidity_sensor_pulse_frame_decoder.sv @@
// Single-wire humidity sensor frame decoder.
// Input channel (i_in_valid / o_in_ready): one transaction per item. i_op low
// starts a new frame and clears the frame state; i_op high carries one
// measured pulse width in i_pulse_width. Widths at or above the leader
// threshold are skipped until the first data bit, and after it they end the
// frame with a protocol error result. Other widths give one bit, MSB first.
// Output channel (o_out_valid / i_out_ready): one transaction per finished
// frame (humidity, temperature, checksum flag) or per protocol error.
// Configuration channel (i_cfg_valid / o_cfg_ready): index 0 is the leader
// threshold, index 1 the one threshold; other indexes are dropped. Always
// ready; write only while the block is idle.
// A result is registered and appears on the output in the cycle after the pulse
// that completes it is accepted. Throughput: one item per cycle while the output
// slot has space, as the shift and checksum registers update on each item.
// Reset (synchronous, active low): thresholds return to 648 and 423 ticks,
// the frame state clears and the output slot empties.
// Stall: while a result waits and i_out_ready is low, o_in_ready drops;
// when the result is taken, a new item is accepted in the same cycle.
module humidity_sensor_pulse_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [15:0] i_pulse_width,
    // Result transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_humidity,
    output logic [15:0] o_temperature,
    output logic        o_checksum_ok,
    output logic        o_protocol_error,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import hsfd_pkg::*;

    t_thresholds thr;
    t_result     core_result;
    t_result     out_result;
    logic        core_emit;
    logic        slot_free;
    logic        in_accept;

    assign o_cfg_ready = 1'b1;

    hsfd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_thr      (thr)
    );

    // Advance the frame only on an accepted transaction
    assign o_in_ready = slot_free;
    assign in_accept  = i_in_valid && o_in_ready;

    hsfd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_op          (i_op),
        .i_pulse_width (i_pulse_width),
        .i_thr         (thr),
        .o_emit        (core_emit),
        .o_result      (core_result)
    );

    // Hold the result until the receiver takes it
    hsfd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept && core_emit),
        .i_result (core_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result),
        .o_space  (slot_free)
    );

    assign o_humidity       = out_result.humidity;
    assign o_temperature    = out_result.temperature;
    assign o_checksum_ok    = out_result.checksum_ok;
    assign o_protocol_error = out_result.protocol_error;

endmodule

@@ hw/rtl/hsfd_cfg_regs.sv @@
module hsfd_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [1:0]           i_wr_index,
    input  logic [15:0]          i_wr_data,
    output hsfd_pkg::t_thresholds o_thr
);
    import hsfd_pkg::*;

    t_thresholds r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.leader <= LEADER_THR_RST;
            r_thr.one    <= ONE_THR_RST;
        end else if (i_wr_en) begin
            // Writes to unknown indexes are dropped
            if (i_wr_index == CFG_LEADER_THR) begin
                r_thr.leader <= i_wr_data;
            end else if (i_wr_index == CFG_ONE_THR) begin
                r_thr.one <= i_wr_data;
            end
        end
    end

    assign o_thr = r_thr;

endmodule

@@ hw/rtl/hsfd_core.sv @@
module hsfd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_op,
    input  logic [15:0]           i_pulse_width,
    input  hsfd_pkg::t_thresholds i_thr,
    output logic                  o_emit,
    output hsfd_pkg::t_result     o_result
);
    import hsfd_pkg::*;

    logic [15:0]        r_hum, n_hum;
    logic [15:0]        r_temp, n_temp;
    logic [7:0]         r_csum, n_csum;
    logic [7:0]         r_sum, n_sum;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_leaders_ok, n_leaders_ok;
    logic               r_done, n_done;

    logic is_leader;
    logic data_bit;

    assign is_leader = (i_pulse_width >= i_thr.leader);
    assign data_bit  = (i_pulse_width >= i_thr.one);

    always_comb begin
        n_hum        = r_hum;
        n_temp       = r_temp;
        n_csum       = r_csum;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_leaders_ok = r_leaders_ok;
        n_done       = r_done;
        o_emit       = 1'b0;
        o_result     = '0;

        if (t_op'(i_op) == OP_START) begin
            n_hum        = '0;
            n_temp       = '0;
            n_csum       = '0;
            n_sum        = '0;
            n_cnt        = '0;
            n_leaders_ok = 1'b1;
            n_done       = 1'b0;
        end else if (!r_done) begin
            if (is_leader) begin
                if (!r_leaders_ok) begin
                    n_done                  = 1'b1;
                    o_emit                  = 1'b1;
                    o_result.protocol_error = 1'b1;
                end
            end else begin
                n_leaders_ok = 1'b0;
                // Shift the bit into the field that the count selects
                if (r_cnt < CNT_HUM_END) begin
                    n_hum = {r_hum[14:0], data_bit};
                end else if (r_cnt < CNT_TEMP_END) begin
                    n_temp = {r_temp[14:0], data_bit};
                end else begin
                    n_csum = {r_csum[6:0], data_bit};
                end
                n_cnt = r_cnt + 1'b1;

                priority if (n_cnt == CNT_HUM_HI || n_cnt == CNT_HUM_END) begin
                    n_sum = r_sum + n_hum[7:0];
                end else if (n_cnt == CNT_TEMP_HI || n_cnt == CNT_TEMP_END) begin
                    n_sum = r_sum + n_temp[7:0];
                end else if (n_cnt >= CNT_FRAME) begin
                    n_done               = 1'b1;
                    o_emit               = 1'b1;
                    o_result.humidity    = n_hum;
                    o_result.temperature = n_temp;
                    o_result.checksum_ok = (r_sum == n_csum);
                end else begin
                    n_sum = r_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hum        <= '0;
            r_temp       <= '0;
            r_csum       <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_leaders_ok <= 1'b1;
            r_done       <= 1'b0;
        end else if (i_accept) begin
            r_hum        <= n_hum;
            r_temp       <= n_temp;
            r_csum       <= n_csum;
            r_sum        <= n_sum;
            r_cnt        <= n_cnt;
            r_leaders_ok <= n_leaders_ok;
            r_done       <= n_done;
        end
    end

endmodule

@@ hw/rtl/hsfd_out_reg.sv @@
module hsfd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hsfd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output hsfd_pkg::t_result o_result,
    output logic              o_space
);
    import hsfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Slot is free when empty or drained in this cycle
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
